@@ rtl/core/cubemap_face_texel_select_core_defines.svh @@
// Assertion macros shared by the cube map face/texel select RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CUBEMAP_FACE_TEXEL_SELECT_CORE_DEFINES_SVH
`define CUBEMAP_FACE_TEXEL_SELECT_CORE_DEFINES_SVH

// Checked only while out of reset.
`define CFTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/cfts_pkg.sv @@
// Shared types and constants for the cube map face/texel select core.
// No dependencies; used by every module of the block.
package cfts_pkg;

    localparam int DIR_W         = 16;
    localparam int DOT_W         = DIR_W + 1;     // negated -1.0 needs one more bit
    localparam int DIR_FRAC_BITS = 15;
    localparam int COORD_FRAC    = DIR_FRAC_BITS + 16;
    localparam int INV_SQRT2_Q16 = 46341;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int TEX_W         = 12;
    localparam int FACE_W        = 3;
    localparam int DEF_MAX_FACE_SIZE = 4096;
    localparam int SIZE_RESET    = 256;
    localparam int Q_DEPTH       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT = 2'd1;

    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd2;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              no_face;
        logic [DOT_W-1:0]  side_dot;  // signed, column axis
        logic [DOT_W-1:0]  up_dot;    // signed, row axis
    } t_item;

endpackage

@@ rtl/core/cfts_front.sv @@
// Front end: face selection and axis pick for one direction item.
// Depends on cfts_pkg.
module cfts_front (
    input  logic [cfts_pkg::DIR_W-1:0] i_dir_x,
    input  logic [cfts_pkg::DIR_W-1:0] i_dir_y,
    input  logic [cfts_pkg::DIR_W-1:0] i_dir_z,
    output cfts_pkg::t_item            o_item
);
    import cfts_pkg::*;

    logic signed [DOT_W-1:0] dx, dy, dz;
    logic signed [DOT_W-1:0] dots [6];
    logic signed [DOT_W-1:0] best;
    logic [FACE_W-1:0]       face;
    logic                    found;
    logic signed [DOT_W-1:0] up_dot, side_dot;

    always_comb begin
        dx = {i_dir_x[DIR_W-1], i_dir_x};
        dy = {i_dir_y[DIR_W-1], i_dir_y};
        dz = {i_dir_z[DIR_W-1], i_dir_z};
        dots[0] = -dz;
        dots[1] = dx;
        dots[2] = dz;
        dots[3] = -dx;
        dots[4] = dy;
        dots[5] = -dy;
        best  = '0;
        face  = FACE_FRONT;
        found = 1'b0;
        // strict compare keeps ties on the earlier face
        for (int i = 0; i < 6; i++) begin
            if (dots[i] > best) begin
                best  = dots[i];
                face  = FACE_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (face)
            FACE_FRONT: begin
                up_dot = dy;  side_dot = -dx;
            end
            FACE_RIGHT: begin
                up_dot = dy;  side_dot = -dz;
            end
            FACE_BACK: begin
                up_dot = dy;  side_dot = dx;
            end
            FACE_LEFT: begin
                up_dot = dy;  side_dot = dz;
            end
            FACE_TOP: begin
                up_dot = dz;  side_dot = -dx;
            end
            default: begin
                up_dot = -dz; side_dot = -dx;
            end
        endcase
    end

    assign o_item.face     = face;
    assign o_item.no_face  = !found;
    assign o_item.side_dot = side_dot;
    assign o_item.up_dot   = up_dot;

endmodule

@@ rtl/core/cfts_queue.sv @@
// Short item queue between front and back end.
// Depends on cfts_pkg and the shared assertion macros.
`include "cubemap_face_texel_select_core_defines.svh"
module cfts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfts_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cfts_pkg::t_item o_item
);
    import cfts_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CFTS_ASSERT_ALWAYS(a_count_max, i_clk, !i_rst_n || r_count <= CNT_W'(Q_DEPTH), "overfill")
    `CFTS_ASSERT(a_ptr_gap, i_clk, i_rst_n, PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_count), "gap")

endmodule

@@ rtl/core/cfts_back.sv @@
// Back end: texel index math for side and up axes, three elastic stages.
// Depends on cfts_pkg and the shared assertion macros.
`include "cubemap_face_texel_select_core_defines.svh"
module cfts_back #(
    parameter int MAX_FACE_SIZE = cfts_pkg::DEF_MAX_FACE_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cfts_pkg::t_item             i_item,
    output logic                        o_pop,
    input  logic [cfts_pkg::CFG_W-1:0]  i_face_width,
    input  logic [cfts_pkg::CFG_W-1:0]  i_face_height,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cfts_pkg::FACE_W-1:0] o_face,
    output logic [cfts_pkg::TEX_W-1:0]  o_texel_x,
    output logic [cfts_pkg::TEX_W-1:0]  o_texel_y,
    output logic                        o_no_face
);
    import cfts_pkg::*;

    localparam int LIM_W  = $clog2(MAX_FACE_SIZE);
    localparam int PROD_W = DOT_W + 17;
    localparam int U_W    = PROD_W + 1;
    localparam int UP_W   = U_W - 1;
    localparam int MUL_W  = UP_W + LIM_W;
    localparam int IDX_W  = MUL_W - COORD_FRAC;
    localparam logic signed [16:0]    K_S    = 17'sd46341;
    localparam logic signed [U_W-1:0] HALF_U = U_W'(64'd1 << (COORD_FRAC - 1));

    function automatic logic [LIM_W-1:0] lim_of(input logic [CFG_W-1:0] sz);
        logic [LIM_W-1:0] r;
        if (sz == '0) begin
            r = '0;
        end else if (32'(sz) > MAX_FACE_SIZE) begin
            r = LIM_W'(MAX_FACE_SIZE - 1);
        end else begin
            r = LIM_W'(sz - CFG_W'(1));
        end
        return r;
    endfunction

    logic [LIM_W-1:0] lim [2];
    logic             rdy1, rdy2, rdy_o;

    // stage 1: dot times 1/sqrt2
    logic                     r_v1, r_nf1;
    logic [FACE_W-1:0]        r_face1;
    logic signed [PROD_W-1:0] r_p1 [2];
    logic signed [DOT_W-1:0]  d [2];

    // stage 2: offset and scale by size - 1
    logic                     r_v2, r_nf2;
    logic [FACE_W-1:0]        r_face2;
    logic [MUL_W-1:0]         r_m2 [2];
    logic [MUL_W-1:0]         n_m2 [2];
    logic signed [U_W-1:0]    u [2];

    // output stage: shift and clamp
    logic                     r_vo, r_nf_o;
    logic [FACE_W-1:0]        r_face_o;
    logic [TEX_W-1:0]         r_tx, r_ty;
    logic [TEX_W-1:0]         n_tex [2];
    logic [IDX_W-1:0]         idx [2];

    assign lim[0] = lim_of(i_face_width);
    assign lim[1] = lim_of(i_face_height);

    assign rdy_o = !r_vo || i_ready;
    assign rdy2  = !r_v2 || rdy_o;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = i_valid && rdy1;

    assign d[0] = $signed(i_item.side_dot);
    assign d[1] = $signed(i_item.up_dot);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            u[l] = HALF_U - r_p1[l];
            if (!u[l][U_W-1] && (u[l] != '0)) begin
                n_m2[l] = MUL_W'(u[l][UP_W-1:0]) * MUL_W'(lim[l]);
            end else begin
                n_m2[l] = '0;
            end
            idx[l] = r_m2[l][MUL_W-1:COORD_FRAC];
            if (r_nf2) begin
                n_tex[l] = '0;
            end else if (idx[l] > IDX_W'(lim[l])) begin
                n_tex[l] = TEX_W'(lim[l]);
            end else begin
                n_tex[l] = TEX_W'(idx[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_face1 <= i_item.face;
            r_nf1   <= i_item.no_face;
            for (int l = 0; l < 2; l++) begin
                r_p1[l] <= d[l] * K_S;
            end
        end
        if (rdy2) begin
            r_face2 <= r_face1;
            r_nf2   <= r_nf1;
            for (int l = 0; l < 2; l++) begin
                r_m2[l] <= n_m2[l];
            end
        end
        if (rdy_o) begin
            r_face_o <= r_nf2 ? FACE_FRONT : r_face2;
            r_nf_o   <= r_nf2;
            r_tx     <= n_tex[0];
            r_ty     <= n_tex[1];
        end
    end

    assign o_valid   = r_vo;
    assign o_face    = r_face_o;
    assign o_texel_x = r_tx;
    assign o_texel_y = r_ty;
    assign o_no_face = r_nf_o;

    `CFTS_ASSERT(a_noface_zero, i_clk, i_rst_n, (r_vo && r_nf_o) |-> (r_face_o == FACE_FRONT && r_tx == '0 && r_ty == '0), "no-face item carries nonzero fields")
    `CFTS_ASSERT(a_face_range, i_clk, i_rst_n, r_vo |-> (r_face_o <= FACE_BOTTOM), "face code out of range")
    `CFTS_ASSERT(a_tex_clamp, i_clk, i_rst_n, r_vo |-> (r_tx <= TEX_W'(lim[0]) && r_ty <= TEX_W'(lim[1])), "texel index above face limit")

endmodule

@@ rtl/core/cubemap_face_texel_select_core.sv @@
// Cube map face select and texel addressing, top level.
// Path: an accepted item is written to the queue, then passes the product stage, the scale
// stage and the output register; it waits behind any items already held in the queue.
// Throughput: one item per cycle while m_axis_tready is high, set by the fully pipelined two-lane back end.
// Reset (synchronous, active low) empties queue and stages; sizes go to 256.
module cubemap_face_texel_select_core #(
    parameter int MAX_FACE_SIZE = cfts_pkg::DEF_MAX_FACE_SIZE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfts_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [47:0]                    s_axis_tdata,  // dir_x, dir_y, dir_z
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // face, texel_x, texel_y, zero pad
    output logic                           m_axis_tuser   // no_face
);
    import cfts_pkg::*;

    logic [CFG_W-1:0]  r_face_width, r_face_height;
    t_item             front_item, q_item;
    logic              q_full, q_valid, q_pop;
    logic [FACE_W-1:0] face;
    logic [TEX_W-1:0]  texel_x, texel_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= CFG_W'(SIZE_RESET);
            r_face_height <= CFG_W'(SIZE_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
                REG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfts_front u_front (
        .i_dir_x (s_axis_tdata[15:0]),
        .i_dir_y (s_axis_tdata[31:16]),
        .i_dir_z (s_axis_tdata[47:32]),
        .o_item  (front_item)
    );

    assign s_axis_tready = !q_full;

    cfts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cfts_back #(
        .MAX_FACE_SIZE (MAX_FACE_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .i_face_width  (r_face_width),
        .i_face_height (r_face_height),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_face        (face),
        .o_texel_x     (texel_x),
        .o_texel_y     (texel_y),
        .o_no_face     (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, texel_y, texel_x, face};

endmodule
